### sv/bhpq_pkg.sv
// bhpq_pkg: shared types and constants of the binary heap priority queue.
// Holds the operation and status codes, register map and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package bhpq_pkg;

  localparam int KEY_W       = 32;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int CFG_LIMIT_W = 7;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Register indexes (word address bit 2)
  localparam logic REG_MIN_MODE  = 1'b0;
  localparam logic REG_CAP_LIMIT = 1'b1;

  localparam logic [CFG_LIMIT_W-1:0] CAP_LIMIT_RESET = 7'd64;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_UP_RD  = 10'b00_0000_0010,
    S_UP_EV  = 10'b00_0000_0100,
    S_POP_RD = 10'b00_0000_1000,
    S_POP_LD = 10'b00_0001_0000,
    S_PK_RD  = 10'b00_0010_0000,
    S_PK_LD  = 10'b00_0100_0000,
    S_DN_RD  = 10'b00_1000_0000,
    S_DN_L   = 10'b01_0000_0000,
    S_DN_R   = 10'b10_0000_0000
  } state_t;

endpackage

### sv/bhpq_cmp.sv
// bhpq_cmp: the shared key comparator of the heap sequencer.
// Strict "a ranks before b" on signed keys, min or max order by mode.
// Depends on bhpq_pkg.
`timescale 1ns / 1ps

module bhpq_cmp
  import bhpq_pkg::*;
(
  input  logic signed [KEY_W-1:0] a,
  input  logic signed [KEY_W-1:0] b,
  input  logic                    min_mode,
  output logic                    better
);

  // Ties never rank before, in either order
  assign better = min_mode ? (a < b) : (a > b);

endmodule

### sv/binary_heap_priority_queue.sv
// binary_heap_priority_queue: top level of the heap based priority queue.
// Depends on bhpq_pkg and bhpq_cmp.
//
// Usage: present kind/key/tag with start high; the word is taken at the edge
// where start is high and busy is low. Unless finished from idle, busy then
// stays high until the result is settled. Each operation yields one result
// word on status, root_key, root_tag and fill_count, marked by done for one
// cycle; the receiver cannot stall, so it must take the word in that cycle.
// Refused push, empty pop/peek and the unused kind are finished from idle:
// done follows in the next cycle. Peek reads the root, then loads it. A push
// climbs level by level, each level a read of the parent and then a compare,
// and ends at the root or where it stops below it; popping the last entry
// loads it and ends, any other pop sinks level by level, each level a read of
// both children and then a compare with each. The pace is set by the single
// comparator and the registered read of the entry memory. A new word may be
// started in the cycle done is high.
// Reset empties the heap at once (fill count to zero, no clearing pass),
// sets min_mode to 1 and capacity_limit to 64. The registers sit on an APB
// port at byte 0 (min_mode) and byte 4 (capacity_limit); write them only while
// busy is low and no result is pending.
`timescale 1ns / 1ps

module binary_heap_priority_queue
  import bhpq_pkg::*;
#(
  parameter int HEAP_DEPTH = 64,
  parameter int TAG_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [KIND_W-1:0]             kind,
  input  logic signed [KEY_W-1:0]       key,
  input  logic [TAG_BITS-1:0]           tag,
  // result channel
  output logic                          done,
  output logic [STATUS_W-1:0]           status,
  output logic signed [KEY_W-1:0]       root_key,
  output logic [TAG_BITS-1:0]           root_tag,
  output logic [$clog2(HEAP_DEPTH+1)-1:0] fill_count,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_W-1:0]         paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready
);

  localparam int IDX_W = $clog2(HEAP_DEPTH);
  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int CH_W  = IDX_W + 2;
  localparam int LIM_W = (CNT_W > CFG_LIMIT_W) ? CNT_W : CFG_LIMIT_W;

  // Configuration registers
  logic                   min_mode;
  logic [CFG_LIMIT_W-1:0] capacity_limit;

  // Sequencer registers
  state_t                 state, state_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [IDX_W-1:0]       pos, pos_next;
  logic signed [KEY_W-1:0] carry_key, carry_key_next;
  logic [TAG_BITS-1:0]    carry_tag, carry_tag_next;
  logic signed [KEY_W-1:0] res_key, res_key_next;
  logic [TAG_BITS-1:0]    res_tag, res_tag_next;
  logic                   pick_l, pick_l_next;

  // Entry memory
  logic signed [KEY_W-1:0] key_mem [HEAP_DEPTH];
  logic [TAG_BITS-1:0]     tag_mem [HEAP_DEPTH];
  logic                    we, rd_en;
  logic [IDX_W-1:0]        wa, ra, rb;
  logic signed [KEY_W-1:0] wkey;
  logic [TAG_BITS-1:0]     wtag;
  logic signed [KEY_W-1:0] rd_key_a, rd_key_b;
  logic [TAG_BITS-1:0]     rd_tag_a, rd_tag_b;

  // Shared comparator
  logic signed [KEY_W-1:0] cmp_a, cmp_b;
  logic                    cmp_better;

  logic                    accept, finish, heap_full;
  logic [STATUS_W-1:0]     fin_status;
  logic [IDX_W-1:0]        up_idx;
  logic [CH_W-1:0]         lchild, rchild, count_ch;
  logic                    l_ok, r_ok;
  logic signed [KEY_W-1:0] pick_key;
  logic                    cfg_wr;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;

  assign heap_full = (LIM_W'(count) >= LIM_W'(capacity_limit)) ||
                     (LIM_W'(count) >= LIM_W'(HEAP_DEPTH));

  assign up_idx   = (pos - IDX_W'(1)) >> 1;
  assign count_ch = CH_W'(count);
  assign lchild   = CH_W'({pos, 1'b1});
  assign rchild   = CH_W'({pos, 1'b0}) + CH_W'(2);
  assign l_ok     = lchild < count_ch;
  assign r_ok     = rchild < count_ch;
  assign pick_key = pick_l ? rd_key_a : carry_key;

  bhpq_cmp u_cmp (
    .a        (cmp_a),
    .b        (cmp_b),
    .min_mode (min_mode),
    .better   (cmp_better)
  );

  always_comb begin
    case (state)
      S_UP_EV: begin
        cmp_a = carry_key;
        cmp_b = rd_key_a;
      end
      S_DN_L: begin
        cmp_a = rd_key_a;
        cmp_b = carry_key;
      end
      S_DN_R: begin
        cmp_a = rd_key_b;
        cmp_b = pick_key;
      end
      default: begin
        cmp_a = carry_key;
        cmp_b = rd_key_a;
      end
    endcase
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    pos_next       = pos;
    carry_key_next = carry_key;
    carry_tag_next = carry_tag;
    res_key_next   = res_key;
    res_tag_next   = res_tag;
    pick_l_next    = pick_l;
    finish         = 1'b0;
    fin_status     = ST_OK;
    we             = 1'b0;
    wa             = pos;
    wkey           = carry_key;
    wtag           = carry_tag;
    rd_en          = 1'b0;
    ra             = '0;
    rb             = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_key_next = '0;
          res_tag_next = '0;
          case (kind)
            KIND_PUSH: begin
              if (heap_full) begin
                finish     = 1'b1;
                fin_status = ST_FULL;
              end else begin
                carry_key_next = key;
                carry_tag_next = tag;
                pos_next       = IDX_W'(count);
                count_next     = count + CNT_W'(1);
                state_next     = S_UP_RD;
              end
            end
            KIND_POP, KIND_PEEK: begin
              if (count == '0) begin
                finish     = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                state_next = (kind == KIND_POP) ? S_POP_RD : S_PK_RD;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      S_UP_RD: begin
        if (pos == '0) begin
          we         = 1'b1;
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          ra         = up_idx;
          state_next = S_UP_EV;
        end
      end
      S_UP_EV: begin
        we = 1'b1;
        if (cmp_better) begin
          // move the parent down into the hole and climb
          wkey       = rd_key_a;
          wtag       = rd_tag_a;
          pos_next   = up_idx;
          state_next = S_UP_RD;
        end else begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP_RD: begin
        rd_en      = 1'b1;
        ra         = '0;
        rb         = IDX_W'(count - CNT_W'(1));
        state_next = S_POP_LD;
      end
      S_POP_LD: begin
        res_key_next   = rd_key_a;
        res_tag_next   = rd_tag_a;
        carry_key_next = rd_key_b;
        carry_tag_next = rd_tag_b;
        count_next     = count - CNT_W'(1);
        pos_next       = '0;
        if (count == CNT_W'(1)) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_DN_RD;
        end
      end
      S_PK_RD: begin
        rd_en      = 1'b1;
        ra         = '0;
        state_next = S_PK_LD;
      end
      S_PK_LD: begin
        res_key_next = rd_key_a;
        res_tag_next = rd_tag_a;
        finish       = 1'b1;
        state_next   = S_IDLE;
      end
      S_DN_RD: begin
        rd_en      = 1'b1;
        ra         = l_ok ? lchild[IDX_W-1:0] : '0;
        rb         = r_ok ? rchild[IDX_W-1:0] : '0;
        state_next = S_DN_L;
      end
      S_DN_L: begin
        pick_l_next = l_ok && cmp_better;
        state_next  = S_DN_R;
      end
      S_DN_R: begin
        we = 1'b1;
        if (r_ok && cmp_better) begin
          wkey       = rd_key_b;
          wtag       = rd_tag_b;
          pos_next   = rchild[IDX_W-1:0];
          state_next = S_DN_RD;
        end else if (pick_l) begin
          wkey       = rd_key_a;
          wtag       = rd_tag_a;
          pos_next   = lchild[IDX_W-1:0];
          state_next = S_DN_RD;
        end else begin
          // hole has settled: drop the carried entry in
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wa] <= wkey;
      tag_mem[wa] <= wtag;
    end
    if (rd_en) begin
      rd_key_a <= key_mem[ra];
      rd_tag_a <= tag_mem[ra];
      rd_key_b <= key_mem[rb];
      rd_tag_b <= tag_mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= finish;
    end
    pos       <= pos_next;
    carry_key <= carry_key_next;
    carry_tag <= carry_tag_next;
    res_key   <= res_key_next;
    res_tag   <= res_tag_next;
    pick_l    <= pick_l_next;
    if (finish) begin
      status     <= fin_status;
      root_key   <= res_key_next;
      root_tag   <= res_tag_next;
      fill_count <= count_next;
    end
  end

  // Configuration registers
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_mode       <= 1'b1;
      capacity_limit <= CAP_LIMIT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MIN_MODE) begin
        min_mode <= pwdata[0];
      end else begin
        capacity_limit <= pwdata[CFG_LIMIT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_CAP_LIMIT) ? APB_DATA_W'(capacity_limit)
                                               : APB_DATA_W'(min_mode);

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    LIM_W'(count) <= LIM_W'(HEAP_DEPTH))
    else $error("entry count beyond heap depth");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted word neither in progress nor finished");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result strobe without a command");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (root_key == '0 && root_tag == '0))
    else $error("refused command returned an entry");

endmodule

### tb/tb_binary_heap_priority_queue.sv
// tb_binary_heap_priority_queue: self-checking bench for the binary heap priority queue.
// Drives push/pop/peek words and APB register writes, and predicts every result word.
// Depends on bhpq_pkg and binary_heap_priority_queue.
`timescale 1ns / 1ps

module tb_binary_heap_priority_queue;
  import bhpq_pkg::*;

  localparam int HEAP_DEPTH   = 64;
  localparam int TAG_BITS     = 8;
  localparam int FILL_W       = $clog2(HEAP_DEPTH + 1);
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 10;
  localparam int NO_CHANGE    = -1;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] key;
    logic [TAG_BITS-1:0]     tag;
    logic [FILL_W-1:0]       fill;
  } heap_result_t;

  typedef struct {
    int                      new_limit;
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] key;
    logic [TAG_BITS-1:0]     tag;
    bit                      typed;
    heap_result_t            res;
  } op_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [KIND_W-1:0]       kind = KIND_PUSH;
  logic signed [KEY_W-1:0] key = '0;
  logic [TAG_BITS-1:0]     tag = '0;
  logic                    done;
  logic [STATUS_W-1:0]     status;
  logic signed [KEY_W-1:0] root_key;
  logic [TAG_BITS-1:0]     root_tag;
  logic [FILL_W-1:0]       fill_count;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  // shadow copy of the heap
  logic signed [KEY_W-1:0] shadow_key [HEAP_DEPTH];
  logic [TAG_BITS-1:0]     shadow_tag [HEAP_DEPTH];
  int                      shadow_fill;
  bit                      shadow_min_mode;
  int                      shadow_limit;

  heap_result_t heap_results_due [$];
  op_row_t      directed_rows [$];
  int           err_count = 0;
  int           cycle_count = 0;
  bit           steady = 1'b0;

  always #4 clk = ~clk;

  binary_heap_priority_queue #(
    .HEAP_DEPTH(HEAP_DEPTH),
    .TAG_BITS  (TAG_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .key       (key),
    .tag       (tag),
    .done      (done),
    .status    (status),
    .root_key  (root_key),
    .root_tag  (root_tag),
    .fill_count(fill_count),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  function automatic bit ranks_above(logic signed [KEY_W-1:0] a, logic signed [KEY_W-1:0] b);
    return shadow_min_mode ? (a < b) : (a > b);
  endfunction

  function automatic void swap_slots(int x, int y);
    logic signed [KEY_W-1:0] k;
    logic [TAG_BITS-1:0]     t;
    k = shadow_key[x];
    t = shadow_tag[x];
    shadow_key[x] = shadow_key[y];
    shadow_tag[x] = shadow_tag[y];
    shadow_key[y] = k;
    shadow_tag[y] = t;
  endfunction

  function automatic heap_result_t heap_predict(logic [KIND_W-1:0] op,
                                                logic signed [KEY_W-1:0] k,
                                                logic [TAG_BITS-1:0] t);
    heap_result_t r;
    int           cap;
    int           pos;
    int           up;
    int           pick;
    bit           moving;
    r = '0;
    cap = (shadow_limit > HEAP_DEPTH) ? HEAP_DEPTH : shadow_limit;
    case (op)
      KIND_PUSH: begin
        if (shadow_fill >= cap) begin
          r.status = ST_FULL;
        end else begin
          shadow_key[shadow_fill] = k;
          shadow_tag[shadow_fill] = t;
          pos = shadow_fill;
          shadow_fill++;
          moving = 1'b1;
          // climb while strictly better than the parent
          while (moving && pos > 0) begin
            up = (pos - 1) / 2;
            if (ranks_above(shadow_key[pos], shadow_key[up])) begin
              swap_slots(pos, up);
              pos = up;
            end else begin
              moving = 1'b0;
            end
          end
        end
      end
      KIND_POP, KIND_PEEK: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.key = shadow_key[0];
          r.tag = shadow_tag[0];
          if (op == KIND_POP) begin
            shadow_fill--;
            if (shadow_fill > 0) begin
              shadow_key[0] = shadow_key[shadow_fill];
              shadow_tag[0] = shadow_tag[shadow_fill];
              pos = 0;
              moving = 1'b1;
              // sink: left child first, right child only if better than that pick
              while (moving) begin
                pick = pos;
                if (2 * pos + 1 < shadow_fill &&
                    ranks_above(shadow_key[2 * pos + 1], shadow_key[pick]))
                  pick = 2 * pos + 1;
                if (2 * pos + 2 < shadow_fill &&
                    ranks_above(shadow_key[2 * pos + 2], shadow_key[pick]))
                  pick = 2 * pos + 2;
                if (pick == pos) begin
                  moving = 1'b0;
                end else begin
                  swap_slots(pos, pick);
                  pos = pick;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.fill = shadow_fill[FILL_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("mismatch on %s: expected %h, got %h at %0t", name, want, got, $realtime);
    end
  endtask

  function automatic int pick_gap();
    if (steady || $urandom_range(0, 99) >= 32)
      return 0;
    return $urandom_range(1, 24);
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 2))
      0: return $signed($urandom_range(0, 8)) - 4;
      1: case ($urandom_range(0, 3))
           0: return 32'sh8000_0000;
           1: return 32'sh7FFF_FFFF;
           2: return 32'sh0000_0000;
           default: return -32'sd1;
         endcase
      default: return $urandom;
    endcase
  endfunction

  // present one word, hold it until taken, and queue its expected result
  task automatic send_word(logic [KIND_W-1:0] op, logic signed [KEY_W-1:0] k,
                           logic [TAG_BITS-1:0] t, bit typed, heap_result_t typed_res);
    int           gap;
    heap_result_t p;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind  <= op;
    key   <= k;
    tag   <= t;
    do @(posedge clk); while (busy);
    p = heap_predict(op, k, t);
    heap_results_due.push_back(typed ? typed_res : p);
  endtask

  // APB write then read back; only with the queue idle
  task automatic set_register(logic reg_idx, logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] mask;
    start <= 1'b0;
    while (heap_results_due.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    if (reg_idx == REG_MIN_MODE) begin
      mask = 32'h1;
      shadow_min_mode = value[0];
    end else begin
      mask = 32'h7F;
      shadow_limit = value[CFG_LIMIT_W-1:0];
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field(reg_idx == REG_MIN_MODE ? "min_mode readback" : "capacity_limit readback",
                value & mask, prdata & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_row(int lim, logic [KIND_W-1:0] op, logic signed [KEY_W-1:0] k,
                         logic [TAG_BITS-1:0] t, bit typed, logic [STATUS_W-1:0] st,
                         logic signed [KEY_W-1:0] rk, logic [TAG_BITS-1:0] rt,
                         logic [FILL_W-1:0] fc);
    op_row_t row;
    row.new_limit = lim;
    row.kind      = op;
    row.key       = k;
    row.tag       = t;
    row.typed     = typed;
    row.res       = '{status: st, key: rk, tag: rt, fill: fc};
    directed_rows.push_back(row);
  endtask

  // result checker: the receiver never stalls, so every strobe is one word
  always @(posedge clk) begin
    heap_result_t want;
    if (!rst && done) begin
      if (heap_results_due.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected result word: status %h key %h tag %h fill %0d",
                   status, root_key, root_tag, fill_count);
      end else begin
        want = heap_results_due.pop_front();
        check_field("status", want.status, status);
        check_field("root_key", want.key, root_key);
        check_field("root_tag", want.tag, root_tag);
        check_field("fill_count", want.fill, fill_count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    bit                ph_mode  [7];
    int                ph_limit [7];
    int                ph_push  [7];
    int                ph_items [7];
    int                r;
    logic [KIND_W-1:0] op;
    op_row_t           row;

    ph_mode  = '{1, 0, 1, 0, 1, 0, 1};
    ph_limit = '{64, 64, 127, 3, 0, 1, 64};
    ph_push  = '{60, 55, 85, 35, 30, 50, 50};
    ph_items = '{60, 60, 90, 60, 40, 40, 60};

    shadow_fill     = 0;
    shadow_min_mode = 1'b1;
    shadow_limit    = 64;

    // directed: empty heap, extremes, unused kind, ties, limits
    add_row(NO_CHANGE, KIND_POP,  0, 8'h00, 1, ST_EMPTY, 0, 8'h00, 0);
    add_row(NO_CHANGE, KIND_PEEK, 0, 8'h00, 1, ST_EMPTY, 0, 8'h00, 0);
    add_row(NO_CHANGE, KIND_NONE, 32'sh7FFF_FFFF, 8'hFF, 1, ST_OK, 0, 8'h00, 0);
    add_row(NO_CHANGE, KIND_PUSH, 32'sh7FFF_FFFF, 8'hFF, 1, ST_OK, 0, 8'h00, 1);
    add_row(NO_CHANGE, KIND_PUSH, 32'sh8000_0000, 8'h00, 1, ST_OK, 0, 8'h00, 2);
    add_row(NO_CHANGE, KIND_PEEK, 0, 8'h00, 1, ST_OK, 32'sh8000_0000, 8'h00, 2);
    add_row(NO_CHANGE, KIND_PUSH, -1, 8'h55, 0, ST_OK, 0, 8'h00, 0);
    add_row(NO_CHANGE, KIND_PUSH, 0, 8'hAA, 0, ST_OK, 0, 8'h00, 0);
    add_row(NO_CHANGE, KIND_PUSH, -1, 8'h33, 0, ST_OK, 0, 8'h00, 0);
    add_row(NO_CHANGE, KIND_PUSH, -1, 8'h0F, 0, ST_OK, 0, 8'h00, 0);
    add_row(NO_CHANGE, KIND_NONE, -1, 8'hF0, 1, ST_OK, 0, 8'h00, 6);
    add_row(NO_CHANGE, KIND_POP,  0, 8'h00, 1, ST_OK, 32'sh8000_0000, 8'h00, 5);
    for (int i = 0; i < 5; i++)
      add_row(NO_CHANGE, KIND_POP, 0, 8'h00, 0, ST_OK, 0, 8'h00, 0);
    add_row(NO_CHANGE, KIND_POP,  0, 8'h00, 1, ST_EMPTY, 0, 8'h00, 0);
    add_row(NO_CHANGE, KIND_PEEK, 0, 8'h00, 1, ST_EMPTY, 0, 8'h00, 0);
    add_row(0,         KIND_PUSH, 5, 8'h01, 1, ST_FULL, 0, 8'h00, 0);
    add_row(1,         KIND_PUSH, 5, 8'h01, 1, ST_OK, 0, 8'h00, 1);
    add_row(NO_CHANGE, KIND_PUSH, 6, 8'h02, 1, ST_FULL, 0, 8'h00, 1);
    add_row(127,       KIND_PUSH, 4, 8'h03, 1, ST_OK, 0, 8'h00, 2);
    add_row(NO_CHANGE, KIND_POP,  0, 8'h00, 0, ST_OK, 0, 8'h00, 0);
    add_row(NO_CHANGE, KIND_POP,  0, 8'h00, 0, ST_OK, 0, 8'h00, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.new_limit != NO_CHANGE)
        set_register(REG_CAP_LIMIT, row.new_limit);
      send_word(row.kind, row.key, row.tag, row.typed, row.res);
    end

    // random phases; the heap carries over, so later limits can sit below the fill
    for (int ph = 0; ph < 7; ph++) begin
      set_register(REG_MIN_MODE, ph_mode[ph]);
      set_register(REG_CAP_LIMIT, ph_limit[ph]);
      for (int i = 0; i < ph_items[ph]; i++) begin
        steady = (ph == 2 && i >= 10 && i < 70);
        r = $urandom_range(0, 99);
        if (r < ph_push[ph])
          op = KIND_PUSH;
        else if (r >= 97)
          op = KIND_NONE;
        else if ($urandom_range(0, 3) == 0)
          op = KIND_PEEK;
        else
          op = KIND_POP;
        send_word(op, pick_key(), TAG_BITS'($urandom_range(0, 255)), 1'b0, '0);
      end
    end
    steady = 1'b0;

    start <= 1'b0;
    while (heap_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
sv/bhpq_pkg.sv
sv/bhpq_cmp.sv
sv/binary_heap_priority_queue.sv
tb/tb_binary_heap_priority_queue.sv
